// ===== rtl/core/pacmp_pkg.sv =====
// Shared constants and types for the polar angle point comparator.
package pacmp_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MODE       = 3'd0,
        CFG_ORIGIN_X   = 3'd1,
        CFG_ORIGIN_Y   = 3'd2,
        CFG_VALUE_TOL  = 3'd3,
        CFG_COSINE_TOL = 3'd4
    } cfg_index_t;

    // Comparison modes
    typedef enum logic {
        MODE_ANGLE = 1'b0,
        MODE_EQUAL = 1'b1
    } cmp_mode_t;

    localparam int TOL_WIDTH = 16;
    // Cosine quotient bits: integer bit plus 30 fraction bits
    localparam int QW = 31;
    localparam int CW = 33;
    localparam logic [QW-1:0] COS_ONE = 31'h4000_0000;

endpackage

// ===== rtl/core/polar_angle_point_comparator.sv =====
// Polar angle point comparator: fully pipelined norm, cosine and order test.
//
// Input channel (s_valid/s_ready) carries two points A and B, signed Q16.16.
// Result channel (m_valid/m_ready) returns one verdict bit per request, in order.
// Mode 0: verdict is 1 when A orders before B by cosine to the origin, then by
// distance. Mode 1: verdict is 1 when both coordinates match within tolerance.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce.
// Pipeline: offset stage, square stage, radicand load, one stage per root bit
// (COORD_WIDTH + 2), the divider load, 31 division stages for the cosine, and
// the output register that also holds the final compare.
// Throughput: one request per cycle while the receiver does not stall the output;
// the square root and divider are unrolled into one stage per bit, so nothing is shared.
// Reset clears all stage valid bits and the configuration registers.
// When a result waits on a stalled receiver, the whole pipeline holds and
// s_ready drops in the same cycle; both advance again once m_ready returns.
module polar_angle_point_comparator #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [(COORD_WIDTH > pacmp_pkg::TOL_WIDTH ?
                   COORD_WIDTH : pacmp_pkg::TOL_WIDTH)-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_first_x,
    input  logic signed [COORD_WIDTH-1:0] s_first_y,
    input  logic signed [COORD_WIDTH-1:0] s_second_x,
    input  logic signed [COORD_WIDTH-1:0] s_second_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_verdict
);

    localparam int DW    = COORD_WIDTH + 1;     // offset width
    localparam int MW    = DW;                  // offset magnitude width
    localparam int SW    = 2 * MW + 1;          // sum of squares width
    localparam int NS    = (SW + 1) / 2;        // root bits, one stage each
    localparam int RADW  = 2 * NS;
    localparam int REMW  = NS + 3;
    localparam int QW    = pacmp_pkg::QW;
    localparam int CW    = pacmp_pkg::CW;
    localparam int TW    = pacmp_pkg::TOL_WIDTH;

    // Configuration registers
    logic                          mode_reg;
    logic signed [COORD_WIDTH-1:0] origin_x_reg;
    logic signed [COORD_WIDTH-1:0] origin_y_reg;
    logic [TW-1:0]                 value_tol_reg;
    logic [TW-1:0]                 cos_tol_reg;

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= pacmp_pkg::MODE_ANGLE;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            value_tol_reg <= '0;
            cos_tol_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                pacmp_pkg::CFG_MODE:       mode_reg      <= cfg_data[0];
                pacmp_pkg::CFG_ORIGIN_X:   origin_x_reg  <= cfg_data[COORD_WIDTH-1:0];
                pacmp_pkg::CFG_ORIGIN_Y:   origin_y_reg  <= cfg_data[COORD_WIDTH-1:0];
                pacmp_pkg::CFG_VALUE_TOL:  value_tol_reg <= cfg_data[TW-1:0];
                pacmp_pkg::CFG_COSINE_TOL: cos_tol_reg   <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves when the output slot frees up
    logic adv;
    assign adv     = !m_valid | m_ready;
    assign s_ready = adv;

    // ---------------- Stage 1: offsets and equality test ----------------
    logic                 v1_reg;
    logic signed [DW-1:0] dx1_reg [2];
    logic signed [DW-1:0] dy1_reg [2];
    logic                 eq1_reg;

    logic signed [DW-1:0] dx1_next [2];
    logic signed [DW-1:0] dy1_next [2];
    logic signed [DW-1:0] ex_diff, ey_diff;
    logic [DW-1:0]        ex_mag, ey_mag;
    logic                 eq1_next;

    // Subtract origin and check coordinate match
    always_comb begin
        dx1_next[0] = DW'(s_first_x)  - DW'(origin_x_reg);
        dy1_next[0] = DW'(s_first_y)  - DW'(origin_y_reg);
        dx1_next[1] = DW'(s_second_x) - DW'(origin_x_reg);
        dy1_next[1] = DW'(s_second_y) - DW'(origin_y_reg);
        ex_diff = DW'(s_first_x) - DW'(s_second_x);
        ey_diff = DW'(s_first_y) - DW'(s_second_y);
        ex_mag  = ex_diff[DW-1] ? DW'(-ex_diff) : DW'(ex_diff);
        ey_mag  = ey_diff[DW-1] ? DW'(-ey_diff) : DW'(ey_diff);
        eq1_next = (ex_mag <= DW'(value_tol_reg)) && (ey_mag <= DW'(value_tol_reg));
    end

    // ---------------- Stage 2: squares ----------------
    logic                v2_reg;
    logic                eq2_reg;
    logic [2*MW-1:0]     sqx2_reg [2];
    logic [2*MW-1:0]     sqy2_reg [2];
    logic [MW-1:0]       mx2_reg [2];
    logic                neg2_reg [2];

    logic [MW-1:0]       mx_mag [2];
    logic [MW-1:0]       my_mag [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mx_mag[l] = dx1_reg[l][DW-1] ? MW'(-dx1_reg[l]) : MW'(dx1_reg[l]);
            my_mag[l] = dy1_reg[l][DW-1] ? MW'(-dy1_reg[l]) : MW'(dy1_reg[l]);
        end
    end

    // ---------------- Stage 3 and root stages ----------------
    logic              sv_reg   [NS+1];
    logic              seq_reg  [NS+1];
    logic [RADW-1:0]   rad_reg  [NS+1][2];
    logic [REMW-1:0]   rem_reg  [NS+1][2];
    logic [NS-1:0]     root_reg [NS+1][2];
    logic [MW-1:0]     sm_reg   [NS+1][2];
    logic              sneg_reg [NS+1][2];

    logic [RADW-1:0]   rad_next  [NS][2];
    logic [REMW-1:0]   rem_next  [NS][2];
    logic [NS-1:0]     root_next [NS][2];

    // One root bit per stage: bring down two radicand bits, try root*4+1
    always_comb begin
        logic [REMW-1:0] r2;
        logic [REMW-1:0] trial;
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < 2; l++) begin
                r2    = {rem_reg[k][l][REMW-3:0], rad_reg[k][l][RADW-1 -: 2]};
                trial = {1'b0, root_reg[k][l], 2'b01};
                rad_next[k][l] = {rad_reg[k][l][RADW-3:0], 2'b00};
                if (r2 >= trial) begin
                    rem_next[k][l]  = r2 - trial;
                    root_next[k][l] = {root_reg[k][l][NS-2:0], 1'b1};
                end else begin
                    rem_next[k][l]  = r2;
                    root_next[k][l] = {root_reg[k][l][NS-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- Division stages for the cosine ----------------
    logic              dv_reg   [QW+1];
    logic              deq_reg  [QW+1];
    logic [NS:0]       drem_reg [QW+1][2];
    logic [QW-1:0]     dq_reg   [QW+1][2];
    logic [NS-1:0]     dn_reg   [QW+1][2];
    logic              dneg_reg [QW+1][2];

    logic [NS:0]       drem_next [QW][2];
    logic [QW-1:0]     dq_next   [QW][2];

    // One quotient bit per stage; stage zero tests m >= n for the integer bit
    always_comb begin
        logic [NS:0] t;
        logic        ge;
        for (int j = 0; j < QW; j++) begin
            for (int l = 0; l < 2; l++) begin
                t  = (j == 0) ? drem_reg[j][l] : {drem_reg[j][l][NS-1:0], 1'b0};
                ge = t >= {1'b0, dn_reg[j][l]};
                drem_next[j][l] = ge ? t - {1'b0, dn_reg[j][l]} : t;
                dq_next[j][l]   = {dq_reg[j][l][QW-2:0], ge};
            end
        end
    end

    // ---------------- Final compare ----------------
    logic signed [CW-1:0] cos_a, cos_b, cdiff, cmag, ctol;
    logic [NS:0]          na_tol;
    logic                 verdict_next;

    always_comb begin
        if (dn_reg[QW][0] == '0)
            cos_a = CW'(pacmp_pkg::COS_ONE);
        else
            cos_a = dneg_reg[QW][0] ? -CW'(dq_reg[QW][0]) : CW'(dq_reg[QW][0]);
        if (dn_reg[QW][1] == '0)
            cos_b = CW'(pacmp_pkg::COS_ONE);
        else
            cos_b = dneg_reg[QW][1] ? -CW'(dq_reg[QW][1]) : CW'(dq_reg[QW][1]);
        ctol   = $signed(CW'(cos_tol_reg));
        cdiff  = cos_a - cos_b;
        cmag   = cdiff[CW-1] ? -cdiff : cdiff;
        na_tol = {1'b0, dn_reg[QW][0]} + (NS+1)'(value_tol_reg);
        if (mode_reg == pacmp_pkg::MODE_EQUAL)
            verdict_next = deq_reg[QW];
        else
            verdict_next = (cos_a > cos_b + ctol) ||
                           ((cmag < ctol) && (na_tol < {1'b0, dn_reg[QW][1]}));
    end

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            m_valid <= 1'b0;
            for (int k = 0; k <= NS; k++) sv_reg[k] <= 1'b0;
            for (int j = 0; j <= QW; j++) dv_reg[j] <= 1'b0;
        end else if (adv) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            sv_reg[0] <= v2_reg;
            for (int k = 0; k < NS; k++) sv_reg[k+1] <= sv_reg[k];
            dv_reg[0] <= sv_reg[NS];
            for (int j = 0; j < QW; j++) dv_reg[j+1] <= dv_reg[j];
            m_valid   <= dv_reg[QW];
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            eq1_reg <= eq1_next;
            eq2_reg <= eq1_reg;
            seq_reg[0] <= eq2_reg;
            deq_reg[0] <= seq_reg[NS];
            for (int k = 0; k < NS; k++) seq_reg[k+1] <= seq_reg[k];
            for (int j = 0; j < QW; j++) deq_reg[j+1] <= deq_reg[j];
            for (int l = 0; l < 2; l++) begin
                dx1_reg[l]  <= dx1_next[l];
                dy1_reg[l]  <= dy1_next[l];
                sqx2_reg[l] <= mx_mag[l] * mx_mag[l];
                sqy2_reg[l] <= my_mag[l] * my_mag[l];
                mx2_reg[l]  <= mx_mag[l];
                neg2_reg[l] <= dx1_reg[l][DW-1];
                // Sum of squares loads the root pipeline
                rad_reg[0][l]  <= RADW'({1'b0, sqx2_reg[l]} + {1'b0, sqy2_reg[l]});
                rem_reg[0][l]  <= '0;
                root_reg[0][l] <= '0;
                sm_reg[0][l]   <= mx2_reg[l];
                sneg_reg[0][l] <= neg2_reg[l];
                for (int k = 0; k < NS; k++) begin
                    rad_reg[k+1][l]  <= rad_next[k][l];
                    rem_reg[k+1][l]  <= rem_next[k][l];
                    root_reg[k+1][l] <= root_next[k][l];
                    sm_reg[k+1][l]   <= sm_reg[k][l];
                    sneg_reg[k+1][l] <= sneg_reg[k][l];
                end
                // Norm and magnitude load the divider
                drem_reg[0][l] <= (NS+1)'(sm_reg[NS][l]);
                dq_reg[0][l]   <= '0;
                dn_reg[0][l]   <= root_reg[NS][l];
                dneg_reg[0][l] <= sneg_reg[NS][l];
                for (int j = 0; j < QW; j++) begin
                    drem_reg[j+1][l] <= drem_next[j][l];
                    dq_reg[j+1][l]   <= dq_next[j][l];
                    dn_reg[j+1][l]   <= dn_reg[j][l];
                    dneg_reg[j+1][l] <= dneg_reg[j][l];
                end
            end
            m_verdict <= verdict_next;
        end
    end

    // Stalled pipeline holds its valid bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v1_reg) && $stable(dv_reg[QW]) && $stable(sv_reg[NS]))
        else $error("pipeline valid moved during stall");

    // A result leaves only after its predecessor stage held a request
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !dv_reg[QW] |=> !m_valid)
        else $error("result appeared without a request in the last stage");

    // An accepted request reaches stage one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted request lost at entry");

    // Nothing is valid right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !v1_reg)
        else $error("valid set after reset");

endmodule
